// ===== rtl/core/kst_pkg.sv =====
// ----------------------------------------------------------------------------
// kst_pkg
// Shared types and codes for the keyed usage-record table.
// ----------------------------------------------------------------------------
package kst_pkg;

    localparam logic [2:0] OP_QUERY       = 3'd0;
    localparam logic [2:0] OP_TOGGLE_PIN  = 3'd1;
    localparam logic [2:0] OP_MARK_USED   = 3'd2;
    localparam logic [2:0] OP_SET_FLAGS   = 3'd3;
    localparam logic [2:0] OP_CLEAR_DIRTY = 3'd4;

    localparam logic [2:0] ST_FOUND    = 3'd0;
    localparam logic [2:0] ST_ABSENT   = 3'd1;
    localparam logic [2:0] ST_APPENDED = 3'd2;
    localparam logic [2:0] ST_REPLACED = 3'd3;
    localparam logic [2:0] ST_NOROOM   = 3'd4;

    localparam logic [15:0] USE_MAX = 16'hFFFF;

    typedef struct packed {
        logic [31:0] key;
        logic        pinned;
        logic [15:0] uses;
        logic [31:0] last;
        logic [4:0]  flags;
    } t_rec;

    typedef struct packed {
        logic eq;
        logic lt;
    } t_cmp_res;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  entry_index;
        logic        pinned;
        logic [15:0] use_count;
        logic [31:0] last_use;
        logic [4:0]  flags_out;
        logic        dirty_out;
    } t_res;

endpackage

// ===== rtl/core/kst_in_if.sv =====
// ----------------------------------------------------------------------------
// kst_in_if
// Operation channel: valid/ready handshake with the operation payload.
// ----------------------------------------------------------------------------
interface kst_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [31:0] key;
    logic [31:0] now_time;
    logic [4:0]  launch_flags;

    modport source (output valid, output op, output key, output now_time,
                    output launch_flags, input ready);
    modport sink   (input valid, input op, input key, input now_time,
                    input launch_flags, output ready);
endinterface

// ===== rtl/core/kst_out_if.sv =====
// ----------------------------------------------------------------------------
// kst_out_if
// Result channel: valid/ready handshake with the record report payload.
// ----------------------------------------------------------------------------
interface kst_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  entry_index;
    logic        pinned;
    logic [15:0] use_count;
    logic [31:0] last_use;
    logic [4:0]  flags_out;
    logic        dirty_out;

    modport source (output valid, output status, output entry_index, output pinned,
                    output use_count, output last_use, output flags_out,
                    output dirty_out, input ready);
    modport sink   (input valid, input status, input entry_index, input pinned,
                    input use_count, input last_use, input flags_out,
                    input dirty_out, output ready);
endinterface

// ===== rtl/core/keyed_stat_table_pinned_eviction.sv =====
// ----------------------------------------------------------------------------
// keyed_stat_table_pinned_eviction
// Keyed table of usage records with append, replacement of the oldest
// unpinned record, and a dirty flag. A small sequencer scans the record
// memory through one shared comparator.
//
//   channel  dir  handshake            payload
//   i_in     in   valid/ready          op, key, now_time, launch_flags
//   o_out    out  valid/ready          status, entry_index, pinned,
//                                      use_count, last_use, flags_out,
//                                      dirty_out
//
// An item passes through an accept step, a key scan over the stored entries
// (which stops at a hit), a victim scan over the whole table when the table
// is full and the key is new, and an update step. The single read port of the
// record memory makes each scan read the records one at a time.
// Reset clears the entry count, the dirty bit and the control state; the
// record memory is not cleared. i_in.ready is high only between items; the
// update cycle holds while a previous result waits on o_out.
// ----------------------------------------------------------------------------
module keyed_stat_table_pinned_eviction #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kst_in_if.sink    i_in,
    kst_out_if.source o_out
);
    import kst_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_VSCAN  = 4'b0100,
        S_UPDATE = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [2:0]       r_op, n_op;
    logic [31:0]      r_key, n_key;
    logic [31:0]      r_now, n_now;
    logic [4:0]       r_lf, n_lf;
    logic             r_create, n_create;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_dirty, n_dirty;
    logic [CNT_W-1:0] r_issue, n_issue;
    logic             r_pend, n_pend;
    logic [IDX_W-1:0] r_pend_idx, n_pend_idx;
    logic             r_have, n_have;
    logic [IDX_W-1:0] r_best, n_best;
    logic [31:0]      r_best_last, n_best_last;
    logic [IDX_W-1:0] r_slot, n_slot;
    t_rec             r_rec, n_rec;
    logic [2:0]       r_status, n_status;
    logic             r_hit, n_hit;
    logic             r_out_valid, n_out_valid;
    t_res             r_res, n_res;

    logic             rd_en;
    t_rec             rd_data;
    logic             wr_en;
    t_rec             rec_new;
    logic [CNT_W-1:0] limit;
    logic [31:0]      cmp_a;
    logic [31:0]      cmp_b;
    t_cmp_res         cmp;
    logic             out_free;
    logic [IDX_W+7:0] slot_wide;

    kst_store #(
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_issue[IDX_W-1:0]),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_slot),
        .i_wr_data (rec_new)
    );

    assign cmp_a = (r_state == S_VSCAN) ? rd_data.last : rd_data.key;
    assign cmp_b = (r_state == S_VSCAN) ? r_best_last : r_key;

    kst_cmp u_cmp (
        .i_a   (cmp_a),
        .i_b   (cmp_b),
        .o_res (cmp)
    );

    assign limit     = (r_state == S_VSCAN) ? DEPTH_C : r_count;
    assign rd_en     = ((r_state == S_SCAN) || (r_state == S_VSCAN)) && (r_issue != limit);
    assign out_free  = !r_out_valid || o_out.ready;
    assign slot_wide = {8'd0, r_slot};

    always_comb begin
        rec_new = r_rec;
        case (r_op)
            OP_TOGGLE_PIN: rec_new.pinned = ~r_rec.pinned;
            OP_MARK_USED: begin
                if (r_rec.uses != USE_MAX) begin
                    rec_new.uses = r_rec.uses + 16'd1;
                end
                rec_new.last = r_now;
            end
            OP_SET_FLAGS: rec_new.flags = r_lf;
            default: rec_new = r_rec;
        endcase
    end

    assign wr_en = (r_state == S_UPDATE) && out_free && r_hit &&
                   ((r_op == OP_TOGGLE_PIN) || (r_op == OP_MARK_USED) ||
                    (r_op == OP_SET_FLAGS));

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_key       = r_key;
        n_now       = r_now;
        n_lf        = r_lf;
        n_create    = r_create;
        n_count     = r_count;
        n_dirty     = r_dirty;
        n_issue     = r_issue;
        n_pend      = r_pend;
        n_pend_idx  = r_pend_idx;
        n_have      = r_have;
        n_best      = r_best;
        n_best_last = r_best_last;
        n_slot      = r_slot;
        n_rec       = r_rec;
        n_status    = r_status;
        n_hit       = r_hit;
        n_out_valid = r_out_valid && !o_out.ready;
        n_res       = r_res;

        if (rd_en) begin
            n_issue    = r_issue + 1'b1;
            n_pend     = 1'b1;
            n_pend_idx = r_issue[IDX_W-1:0];
        end else begin
            n_pend     = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_op     = i_in.op;
                    n_key    = i_in.key;
                    n_now    = i_in.now_time;
                    n_lf     = i_in.launch_flags;
                    n_create = (i_in.op == OP_TOGGLE_PIN) || (i_in.op == OP_MARK_USED) ||
                               ((i_in.op == OP_SET_FLAGS) && (i_in.launch_flags != 5'd0));
                    if (i_in.op == OP_CLEAR_DIRTY) begin
                        n_dirty = 1'b0;
                    end
                    n_issue = '0;
                    n_pend  = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_pend && cmp.eq) begin
                    n_slot   = r_pend_idx;
                    n_rec    = rd_data;
                    n_hit    = 1'b1;
                    n_status = ST_FOUND;
                    n_state  = S_UPDATE;
                end else if (!r_pend && (r_issue == r_count)) begin
                    if (!r_create) begin
                        n_hit    = 1'b0;
                        n_status = ST_ABSENT;
                        n_state  = S_UPDATE;
                    end else if (r_count != DEPTH_C) begin
                        n_slot   = r_count[IDX_W-1:0];
                        n_count  = r_count + 1'b1;
                        n_rec    = t_rec'{key: r_key, default: '0};
                        n_hit    = 1'b1;
                        n_status = ST_APPENDED;
                        n_state  = S_UPDATE;
                    end else begin
                        n_issue = '0;
                        n_pend  = 1'b0;
                        n_have  = 1'b0;
                        n_state = S_VSCAN;
                    end
                end
            end
            S_VSCAN: begin
                if (r_pend) begin
                    if (!rd_data.pinned && (!r_have || cmp.lt)) begin
                        n_best      = r_pend_idx;
                        n_best_last = rd_data.last;
                        n_have      = 1'b1;
                    end
                end else if (r_issue == DEPTH_C) begin
                    if (r_have) begin
                        n_slot   = r_best;
                        n_rec    = t_rec'{key: r_key, default: '0};
                        n_hit    = 1'b1;
                        n_status = ST_REPLACED;
                    end else begin
                        n_hit    = 1'b0;
                        n_status = ST_NOROOM;
                    end
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (out_free) begin
                    if (r_hit && ((r_op == OP_TOGGLE_PIN) || (r_op == OP_MARK_USED) ||
                                  ((r_op == OP_SET_FLAGS) && (r_rec.flags != r_lf)))) begin
                        n_dirty = 1'b1;
                    end
                    n_res.status    = r_status;
                    n_res.dirty_out = n_dirty;
                    if (r_hit) begin
                        n_res.entry_index = slot_wide[7:0];
                        n_res.pinned      = rec_new.pinned;
                        n_res.use_count   = rec_new.uses;
                        n_res.last_use    = rec_new.last;
                        n_res.flags_out   = rec_new.flags;
                    end else begin
                        n_res.entry_index = 8'd0;
                        n_res.pinned      = 1'b0;
                        n_res.use_count   = 16'd0;
                        n_res.last_use    = 32'd0;
                        n_res.flags_out   = 5'd0;
                    end
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_dirty     <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dirty     <= n_dirty;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_key       <= n_key;
        r_now       <= n_now;
        r_lf        <= n_lf;
        r_create    <= n_create;
        r_issue     <= n_issue;
        r_pend_idx  <= n_pend_idx;
        r_have      <= n_have;
        r_best      <= n_best;
        r_best_last <= n_best_last;
        r_slot      <= n_slot;
        r_rec       <= n_rec;
        r_status    <= n_status;
        r_hit       <= n_hit;
        r_res       <= n_res;
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_res.status;
    assign o_out.entry_index = r_res.entry_index;
    assign o_out.pinned      = r_res.pinned;
    assign o_out.use_count   = r_res.use_count;
    assign o_out.last_use    = r_res.last_use;
    assign o_out.flags_out   = r_res.flags_out;
    assign o_out.dirty_out   = r_res.dirty_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count beyond table depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> (r_count == $past(r_count) + 1'b1))
        else $error("entry count moved by other than one");

    a_replace_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_UPDATE) && (r_status == ST_REPLACED)) |-> (r_count == DEPTH_C))
        else $error("victim replaced while table not full");

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> !i_in.ready)
        else $error("record write while accepting an item");

endmodule

// ===== rtl/core/kst_store.sv =====
// ----------------------------------------------------------------------------
// kst_store
// Record memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kst_store #(
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output kst_pkg::t_rec            o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  kst_pkg::t_rec            i_wr_data
);
    import kst_pkg::*;

    t_rec r_mem [DEPTH];
    t_rec r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/kst_cmp.sv =====
// ----------------------------------------------------------------------------
// kst_cmp
// Shared 32-bit comparator: key match during lookup, age order during
// victim search.
// ----------------------------------------------------------------------------
module kst_cmp (
    input  logic [31:0]       i_a,
    input  logic [31:0]       i_b,
    output kst_pkg::t_cmp_res o_res
);
    import kst_pkg::*;

    assign o_res.eq = (i_a == i_b);
    assign o_res.lt = (i_a < i_b);

endmodule
